@@ design/plpd_pkg.sv @@
// Shared widths and mode codes for the point to line and plane distance pipeline.
// No dependencies.
package plpd_pkg;

  localparam int COORD_W = 32;          // input coordinate width
  localparam int DIFF_W  = COORD_W + 1; // query minus base, never wraps
  localparam int PROD_W  = DIFF_W + COORD_W;
  localparam int MAG_W   = 65;          // magnitude of a cross component or of the dot product
  localparam int HI_W    = MAG_W - 32;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int NUM_W   = SQ_W + 2;    // sum of three squares
  localparam int DEN_W   = 64;          // squared length of the direction
  localparam int QUO_W   = 64;          // quotient bits kept when not saturated
  localparam int ROOT_W  = QUO_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int DIST_W  = 32;

  localparam logic MODE_LINE  = 1'b0;
  localparam logic MODE_PLANE = 1'b1;

endpackage

@@ design/point_line_plane_distance_3d_top.sv @@
// Pipelined distance from a query point to a line or a plane in 3D.
// Depends on plpd_pkg for widths and mode codes.

// A new item may be started in every clock cycle; busy never rises. Each result beat
// appears on distance, degenerate and saturated for one cycle with done high. The
// receiver cannot hold results off, so it must take every beat as it comes. Each item
// passes through the chain of 64 restoring division stages that form the squared
// distance and the 32 square root stages that follow, each resolving one bit, behind
// seven stages of products, squares and sums and one stage that loads the divider and
// checks for saturation, with one output register at the end.
module point_line_plane_distance_3d_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode,
  input  logic signed [plpd_pkg::COORD_W-1:0] dir_x,
  input  logic signed [plpd_pkg::COORD_W-1:0] dir_y,
  input  logic signed [plpd_pkg::COORD_W-1:0] dir_z,
  input  logic signed [plpd_pkg::COORD_W-1:0] base_x,
  input  logic signed [plpd_pkg::COORD_W-1:0] base_y,
  input  logic signed [plpd_pkg::COORD_W-1:0] base_z,
  input  logic signed [plpd_pkg::COORD_W-1:0] query_x,
  input  logic signed [plpd_pkg::COORD_W-1:0] query_y,
  input  logic signed [plpd_pkg::COORD_W-1:0] query_z,
  output logic                                done,
  output logic        [plpd_pkg::DIST_W-1:0]  distance,
  output logic                                degenerate,
  output logic                                saturated
);
  import plpd_pkg::*;

  // Stage 1: operands and the query offset.
  logic                      v1;
  logic                      m1;
  logic signed [COORD_W-1:0] d1x, d1y, d1z;
  logic signed [DIFF_W-1:0]  o1x, o1y, o1z;

  // Stage 2: products.
  logic                     v2;
  logic                     m2;
  logic signed [63:0]       q2x, q2y, q2z;
  logic signed [PROD_W-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx, p_xx, p_yy, p_zz;

  // Stage 3: cross components, dot product and squared length.
  logic                       v3;
  logic                       m3;
  logic signed [PROD_W:0]     c3x, c3y, c3z;
  logic signed [PROD_W+1:0]   dot3;
  logic        [DEN_W-1:0]    den3;

  // Stage 4: magnitudes to square.
  logic             v4;
  logic             deg4;
  logic [DEN_W-1:0] den4;
  logic [MAG_W-1:0] a4 [3];

  // Stage 5: partial products of the squares.
  logic              v5;
  logic              deg5;
  logic [DEN_W-1:0]  den5;
  logic [2*HI_W-1:0] pp_hh [3];
  logic [HI_W+31:0]  pp_hl [3];
  logic [63:0]       pp_ll [3];

  // Stage 6: squares.
  logic             v6;
  logic             deg6;
  logic [DEN_W-1:0] den6;
  logic [SQ_W-1:0]  sq6 [3];

  // Stage 7: numerator.
  logic             v7;
  logic             deg7;
  logic [DEN_W-1:0] den7;
  logic [NUM_W-1:0] num7;

  // Division chain: remainder and a word that shifts numerator bits out and quotient bits in.
  logic [QUO_W:0]   dv;
  logic             ddeg [QUO_W+1];
  logic             dsat [QUO_W+1];
  logic [DEN_W-1:0] dden [QUO_W+1];
  logic [DEN_W-1:0] drem [QUO_W+1];
  logic [QUO_W-1:0] dqn  [QUO_W+1];

  // Square root chain, two radicand bits a stage.
  logic [ROOT_W:0]   sv;
  logic              sdeg  [ROOT_W+1];
  logic              ssat  [ROOT_W+1];
  logic [QUO_W-1:0]  sx    [ROOT_W+1];
  logic [ROOT_W-1:0] sroot [ROOT_W+1];
  logic [REM_W-1:0]  srem  [ROOT_W+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    m1  <= mode;
    d1x <= dir_x;
    d1y <= dir_y;
    d1z <= dir_z;
    o1x <= DIFF_W'($signed({query_x[COORD_W-1], query_x}) - $signed({base_x[COORD_W-1], base_x}));
    o1y <= DIFF_W'($signed({query_y[COORD_W-1], query_y}) - $signed({base_y[COORD_W-1], base_y}));
    o1z <= DIFF_W'($signed({query_z[COORD_W-1], query_z}) - $signed({base_z[COORD_W-1], base_z}));
  end

  always_ff @(posedge clk) begin
    m2   <= m1;
    q2x  <= 64'(d1x * d1x);
    q2y  <= 64'(d1y * d1y);
    q2z  <= 64'(d1z * d1z);
    p_yz <= PROD_W'(o1y * d1z);
    p_zy <= PROD_W'(o1z * d1y);
    p_zx <= PROD_W'(o1z * d1x);
    p_xz <= PROD_W'(o1x * d1z);
    p_xy <= PROD_W'(o1x * d1y);
    p_yx <= PROD_W'(o1y * d1x);
    p_xx <= PROD_W'(o1x * d1x);
    p_yy <= PROD_W'(o1y * d1y);
    p_zz <= PROD_W'(o1z * d1z);
  end

  always_ff @(posedge clk) begin
    m3   <= m2;
    c3x  <= (PROD_W+1)'($signed({p_yz[PROD_W-1], p_yz}) - $signed({p_zy[PROD_W-1], p_zy}));
    c3y  <= (PROD_W+1)'($signed({p_zx[PROD_W-1], p_zx}) - $signed({p_xz[PROD_W-1], p_xz}));
    c3z  <= (PROD_W+1)'($signed({p_xy[PROD_W-1], p_xy}) - $signed({p_yx[PROD_W-1], p_yx}));
    dot3 <= (PROD_W+2)'($signed({{2{p_xx[PROD_W-1]}}, p_xx})
                        + $signed({{2{p_yy[PROD_W-1]}}, p_yy})
                        + $signed({{2{p_zz[PROD_W-1]}}, p_zz}));
    den3 <= DEN_W'(q2x) + DEN_W'(q2y) + DEN_W'(q2z);
  end

  logic [PROD_W:0]   abs_cx, abs_cy, abs_cz;
  logic [PROD_W+1:0] abs_dot;

  always_comb begin
    abs_cx  = c3x[PROD_W]    ? (PROD_W+1)'(-c3x)  : c3x;
    abs_cy  = c3y[PROD_W]    ? (PROD_W+1)'(-c3y)  : c3y;
    abs_cz  = c3z[PROD_W]    ? (PROD_W+1)'(-c3z)  : c3z;
    abs_dot = dot3[PROD_W+1] ? (PROD_W+2)'(-dot3) : dot3;
  end

  always_ff @(posedge clk) begin
    deg4 <= (den3 == '0);
    den4 <= den3;
    if (m3 == MODE_PLANE) begin
      a4[0] <= abs_dot[MAG_W-1:0];
      a4[1] <= '0;
      a4[2] <= '0;
    end else begin
      a4[0] <= abs_cx[MAG_W-1:0];
      a4[1] <= abs_cy[MAG_W-1:0];
      a4[2] <= abs_cz[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    deg5 <= deg4;
    den5 <= den4;
    for (int i = 0; i < 3; i++) begin
      pp_hh[i] <= (2*HI_W)'(a4[i][MAG_W-1:32] * a4[i][MAG_W-1:32]);
      pp_hl[i] <= (HI_W+32)'(a4[i][MAG_W-1:32] * a4[i][31:0]);
      pp_ll[i] <= 64'(a4[i][31:0] * a4[i][31:0]);
    end
  end

  always_ff @(posedge clk) begin
    deg6 <= deg5;
    den6 <= den5;
    for (int i = 0; i < 3; i++) begin
      sq6[i] <= SQ_W'({pp_hh[i], 64'd0}) + SQ_W'({pp_hl[i], 33'd0}) + SQ_W'(pp_ll[i]);
    end
  end

  always_ff @(posedge clk) begin
    deg7 <= deg6;
    den7 <= den6;
    num7 <= NUM_W'(sq6[0]) + NUM_W'(sq6[1]) + NUM_W'(sq6[2]);
  end

  // The quotient fits in QUO_W bits exactly when the top of the numerator is below the
  // squared length; otherwise the distance is at least 2^32 and saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= v7;
    end
  end

  always_ff @(posedge clk) begin
    ddeg[0] <= deg7;
    dsat[0] <= (num7[NUM_W-1:QUO_W] >= (NUM_W-QUO_W)'(den7));
    dden[0] <= den7;
    drem[0] <= num7[QUO_W+DEN_W-1:QUO_W];
    dqn[0]  <= num7[QUO_W-1:0];
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [DEN_W:0] trial;
    logic           take;

    always_comb begin
      trial = {drem[k], dqn[k][QUO_W-1]};
      take  = (trial >= {1'b0, dden[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      ddeg[k+1] <= ddeg[k];
      dsat[k+1] <= dsat[k];
      dden[k+1] <= dden[k];
      drem[k+1] <= take ? DEN_W'(trial - {1'b0, dden[k]}) : trial[DEN_W-1:0];
      dqn[k+1]  <= {dqn[k][QUO_W-2:0], take};
    end
  end

  always_comb begin
    sv[0]    = dv[QUO_W];
    sdeg[0]  = ddeg[QUO_W];
    ssat[0]  = dsat[QUO_W];
    sx[0]    = dqn[QUO_W];
    sroot[0] = '0;
    srem[0]  = '0;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W+1:0] part;
    logic [REM_W+1:0] test;
    logic             take;

    always_comb begin
      part = {srem[k], sx[k][QUO_W-1:QUO_W-2]};
      test = (REM_W+2)'({sroot[k], 2'b01});
      take = (part >= test);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      sdeg[k+1]  <= sdeg[k];
      ssat[k+1]  <= ssat[k];
      sx[k+1]    <= {sx[k][QUO_W-3:0], 2'b00};
      sroot[k+1] <= {sroot[k][ROOT_W-2:0], take};
      srem[k+1]  <= take ? REM_W'(part - test) : part[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sv[ROOT_W];
    end
  end

  // A zero direction overrides the saturation test, which it always passes.
  always_ff @(posedge clk) begin
    degenerate <= sdeg[ROOT_W];
    saturated  <= ssat[ROOT_W] && !sdeg[ROOT_W];
    if (sdeg[ROOT_W]) begin
      distance <= '0;
    end else if (ssat[ROOT_W]) begin
      distance <= '1;
    end else begin
      distance <= DIST_W'(sroot[ROOT_W]);
    end
  end

endmodule
